// ----- hdl/tlfk_pkg.sv -----
`timescale 1ns / 1ps
package tlfk_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int TRIG_W       = 34;   // CORDIC x/y, Q1.30 with headroom
    localparam int Z_W          = 33;   // residual angle, 32-bit turn plus sign
    localparam int LEG_DROP     = 16;
    localparam int WORLD_DROP   = 28;
    localparam int CFG_IDX_W    = 3;
    localparam int ROW_W        = 48;
    localparam int LEN_W        = 15;
    localparam int OUT_W        = 24;

    localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 34'sh26DD3B6A;

    localparam logic [31:0] TURN_ATAN [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_UPPER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_LOWER = 3'd4;

    localparam logic [ROW_W-1:0] ROW_X_RESET = 48'h4000_0000_0000;
    localparam logic [ROW_W-1:0] ROW_Y_RESET = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RESET = 48'h0000_0000_0000;
    localparam logic [LEN_W-1:0] LEN_RESET   = 15'd2048;

    localparam logic signed [49:0] OUT_MAX = 50'sd8388607;
    localparam logic signed [49:0] OUT_MIN = -50'sd8388608;

    typedef struct packed {
        logic [ROW_W-1:0] row_x;
        logic [ROW_W-1:0] row_y;
        logic [ROW_W-1:0] row_z;
        logic [LEN_W-1:0] len_upper;
        logic [LEN_W-1:0] len_lower;
    } t_cfg;

    // classified angle pair: half-turn flip plus the start angle for CORDIC
    typedef struct packed {
        logic        flip_hip;
        logic [31:0] z_hip;
        logic        flip_sum;
        logic [31:0] z_sum;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// ----- hdl/tlfk_front.sv -----
`timescale 1ns / 1ps
module tlfk_front #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [ANGLE_BITS-1:0]  i_hip_angle,
    input  logic [ANGLE_BITS-1:0]  i_knee_angle,
    input  tlfk_pkg::t_fifo_stat   i_fifo_stat,
    output logic                   o_push,
    output tlfk_pkg::t_entry       o_entry
);

    logic             r_valid;
    tlfk_pkg::t_entry r_entry;
    tlfk_pkg::t_entry n_entry;
    logic [31:0]      w_a_hip;
    logic [31:0]      w_a_knee;
    logic [31:0]      w_a_sum;

    // angles in [90,270) deg get turned by half a turn; result is negated later
    function automatic logic [32:0] classify(input logic [31:0] a);
        logic        flip;
        logic [31:0] q;
        begin
            q    = a + 32'h4000_0000;
            flip = q[31];
            return {flip, flip ? (a + 32'h8000_0000) : a};
        end
    endfunction

    assign w_a_hip  = 32'(i_hip_angle) << (32 - ANGLE_BITS);
    assign w_a_knee = 32'(i_knee_angle) << (32 - ANGLE_BITS);
    assign w_a_sum  = w_a_hip + w_a_knee;

    always_comb begin
        {n_entry.flip_hip, n_entry.z_hip} = classify(w_a_hip);
        {n_entry.flip_sum, n_entry.z_sum} = classify(w_a_sum);
    end

    assign o_push     = r_valid && !i_fifo_stat.full;
    assign o_in_ready = !r_valid || !i_fifo_stat.full;
    assign o_entry    = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_entry <= n_entry;
        end
    end

endmodule

// ----- hdl/tlfk_fifo.sv -----
`timescale 1ns / 1ps
module tlfk_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tlfk_pkg::t_entry     i_entry,
    input  logic                 i_pop,
    output tlfk_pkg::t_entry     o_entry,
    output tlfk_pkg::t_fifo_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tlfk_pkg::t_entry   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_entry      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ----- hdl/tlfk_cordic_stage.sv -----
`timescale 1ns / 1ps
module tlfk_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [tlfk_pkg::TRIG_W-1:0]    i_x,
    input  logic signed [tlfk_pkg::TRIG_W-1:0]    i_y,
    input  logic signed [tlfk_pkg::Z_W-1:0]       i_z,
    output logic signed [tlfk_pkg::TRIG_W-1:0]    o_x,
    output logic signed [tlfk_pkg::TRIG_W-1:0]    o_y,
    output logic signed [tlfk_pkg::Z_W-1:0]       o_z
);

    logic signed [tlfk_pkg::TRIG_W-1:0] r_x;
    logic signed [tlfk_pkg::TRIG_W-1:0] r_y;
    logic signed [tlfk_pkg::Z_W-1:0]    r_z;
    logic signed [tlfk_pkg::TRIG_W-1:0] w_dx;
    logic signed [tlfk_pkg::TRIG_W-1:0] w_dy;
    logic signed [tlfk_pkg::Z_W-1:0]    w_step;

    assign w_dx   = i_y >>> STEP;
    assign w_dy   = i_x >>> STEP;
    assign w_step = $signed({1'b0, tlfk_pkg::TURN_ATAN[STEP]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_z[tlfk_pkg::Z_W-1]) begin
                r_x <= i_x - w_dx;
                r_y <= i_y + w_dy;
                r_z <= i_z - w_step;
            end else begin
                r_x <= i_x + w_dx;
                r_y <= i_y - w_dy;
                r_z <= i_z + w_step;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ----- hdl/tlfk_back.sv -----
`timescale 1ns / 1ps
module tlfk_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tlfk_pkg::t_cfg                    i_cfg,
    input  tlfk_pkg::t_entry                  i_entry,
    input  tlfk_pkg::t_fifo_stat              i_fifo_stat,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [tlfk_pkg::OUT_W-1:0] o_tip_x,
    output logic signed [tlfk_pkg::OUT_W-1:0] o_tip_y,
    output logic signed [tlfk_pkg::OUT_W-1:0] o_tip_z
);

    localparam int N_CORDIC = tlfk_pkg::CORDIC_STEPS;
    // cordic steps, sign fix, leg products, leg sums, world products, world sums
    localparam int STAGES   = N_CORDIC + 5;
    localparam int TW       = tlfk_pkg::TRIG_W;
    localparam int ZW       = tlfk_pkg::Z_W;

    logic                 w_en;
    logic [STAGES-1:0]    r_vld;
    logic                 r_out_valid;
    logic [N_CORDIC-1:0]  r_flip_hip;
    logic [N_CORDIC-1:0]  r_flip_sum;

    logic signed [TW-1:0] w_x_hip [N_CORDIC+1];
    logic signed [TW-1:0] w_y_hip [N_CORDIC+1];
    logic signed [ZW-1:0] w_z_hip [N_CORDIC+1];
    logic signed [TW-1:0] w_x_sum [N_CORDIC+1];
    logic signed [TW-1:0] w_y_sum [N_CORDIC+1];
    logic signed [ZW-1:0] w_z_sum [N_CORDIC+1];

    logic signed [TW-1:0] n_s0, n_c0, n_s01, n_c01;
    logic signed [31:0]   r_s0, r_c0, r_s01, r_c01;
    logic signed [15:0]   w_l1, w_l2;
    logic signed [47:0]   r_p_s0, r_p_s01, r_p_c0, r_p_c01;
    logic signed [48:0]   n_px_acc, n_py_acc;
    logic signed [31:0]   r_px, r_py;
    logic signed [47:0]   r_wx0, r_wx1, r_wy0, r_wy1, r_wz0, r_wz1;
    logic signed [49:0]   r_acc_x, r_acc_y, r_acc_z;
    logic signed [tlfk_pkg::OUT_W-1:0] r_tip_x, r_tip_y, r_tip_z;

    function automatic logic signed [15:0] fld(input logic [47:0] row, input int lsb);
        return $signed(row[lsb +: 16]);
    endfunction

    function automatic logic signed [49:0] world_sum(input logic signed [47:0] a,
                                                     input logic signed [47:0] b,
                                                     input logic signed [15:0] t);
        logic signed [49:0] tt;
        begin
            tt = 50'(t) <<< tlfk_pkg::WORLD_DROP;
            return 50'(a) + 50'(b) + tt + (50'sd1 <<< (tlfk_pkg::WORLD_DROP - 1));
        end
    endfunction

    function automatic logic signed [tlfk_pkg::OUT_W-1:0] sat_out(input logic signed [49:0] v);
        logic signed [49:0] sh;
        begin
            sh = v >>> tlfk_pkg::WORLD_DROP;
            if (sh > tlfk_pkg::OUT_MAX) begin
                return tlfk_pkg::OUT_MAX[tlfk_pkg::OUT_W-1:0];
            end else if (sh < tlfk_pkg::OUT_MIN) begin
                return tlfk_pkg::OUT_MIN[tlfk_pkg::OUT_W-1:0];
            end
            return sh[tlfk_pkg::OUT_W-1:0];
        end
    endfunction

    // whole pipe advances together; the output register decouples the consumer
    assign w_en  = !r_out_valid || i_out_ready;
    assign o_pop = w_en && !i_fifo_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[STAGES-2:0], o_pop};
            r_out_valid <= r_vld[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_flip_hip <= {r_flip_hip[N_CORDIC-2:0], i_entry.flip_hip};
            r_flip_sum <= {r_flip_sum[N_CORDIC-2:0], i_entry.flip_sum};
        end
    end

    assign w_x_hip[0] = tlfk_pkg::CORDIC_X0;
    assign w_y_hip[0] = '0;
    assign w_z_hip[0] = ZW'($signed(i_entry.z_hip));
    assign w_x_sum[0] = tlfk_pkg::CORDIC_X0;
    assign w_y_sum[0] = '0;
    assign w_z_sum[0] = ZW'($signed(i_entry.z_sum));

    for (genvar g = 0; g < N_CORDIC; g++) begin : g_cordic
        tlfk_cordic_stage #(.STEP(g)) u_hip (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (w_x_hip[g]),
            .i_y   (w_y_hip[g]),
            .i_z   (w_z_hip[g]),
            .o_x   (w_x_hip[g+1]),
            .o_y   (w_y_hip[g+1]),
            .o_z   (w_z_hip[g+1])
        );
        tlfk_cordic_stage #(.STEP(g)) u_sum (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (w_x_sum[g]),
            .i_y   (w_y_sum[g]),
            .i_z   (w_z_sum[g]),
            .o_x   (w_x_sum[g+1]),
            .o_y   (w_y_sum[g+1]),
            .o_z   (w_z_sum[g+1])
        );
    end

    // undo the half-turn flip; magnitudes are at most about 1.0 in Q1.30
    always_comb begin
        n_s0  = r_flip_hip[N_CORDIC-1] ? -w_y_hip[N_CORDIC] : w_y_hip[N_CORDIC];
        n_c0  = r_flip_hip[N_CORDIC-1] ? -w_x_hip[N_CORDIC] : w_x_hip[N_CORDIC];
        n_s01 = r_flip_sum[N_CORDIC-1] ? -w_y_sum[N_CORDIC] : w_y_sum[N_CORDIC];
        n_c01 = r_flip_sum[N_CORDIC-1] ? -w_x_sum[N_CORDIC] : w_x_sum[N_CORDIC];
    end

    assign w_l1 = $signed({1'b0, i_cfg.len_upper});
    assign w_l2 = $signed({1'b0, i_cfg.len_lower});

    always_comb begin
        n_px_acc = -(49'(r_p_s0) + 49'(r_p_s01)) + (49'sd1 <<< (tlfk_pkg::LEG_DROP - 1));
        n_py_acc = 49'(r_p_c0) + 49'(r_p_c01) + (49'sd1 <<< (tlfk_pkg::LEG_DROP - 1));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0    <= n_s0[31:0];
            r_c0    <= n_c0[31:0];
            r_s01   <= n_s01[31:0];
            r_c01   <= n_c01[31:0];

            r_p_s0  <= w_l1 * r_s0;
            r_p_s01 <= w_l2 * r_s01;
            r_p_c0  <= w_l1 * r_c0;
            r_p_c01 <= w_l2 * r_c01;

            r_px    <= 32'(n_px_acc >>> tlfk_pkg::LEG_DROP);
            r_py    <= 32'(n_py_acc >>> tlfk_pkg::LEG_DROP);

            r_wx0   <= fld(i_cfg.row_x, 32) * r_px;
            r_wx1   <= fld(i_cfg.row_x, 16) * r_py;
            r_wy0   <= fld(i_cfg.row_y, 32) * r_px;
            r_wy1   <= fld(i_cfg.row_y, 16) * r_py;
            r_wz0   <= fld(i_cfg.row_z, 32) * r_px;
            r_wz1   <= fld(i_cfg.row_z, 16) * r_py;

            r_acc_x <= world_sum(r_wx0, r_wx1, fld(i_cfg.row_x, 0));
            r_acc_y <= world_sum(r_wy0, r_wy1, fld(i_cfg.row_y, 0));
            r_acc_z <= world_sum(r_wz0, r_wz1, fld(i_cfg.row_z, 0));

            r_tip_x <= sat_out(r_acc_x);
            r_tip_y <= sat_out(r_acc_y);
            r_tip_z <= sat_out(r_acc_z);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tip_x     = r_tip_x;
    assign o_tip_y     = r_tip_y;
    assign o_tip_z     = r_tip_z;

endmodule

// ----- hdl/two_link_leg_forward_kinematics.sv -----
`timescale 1ns / 1ps
// Planar two-link leg forward kinematics with a configurable torso offset.
// Takes one hip/knee angle word per cycle while o_in_ready is high, and
// returns one tip position word per input, in order, at a sustained rate
// of one word per clock while the output is not stalled. The accepting edge
// loads the classification register. After that come the input queue, two
// 30-step pipelined CORDIC units (hip angle and hip+knee angle), and six
// stages of sign correction, products, rounding and saturation. A result
// held on the output stalls the back pipeline; the front stage and a small
// queue keep taking input words until the queue fills. Configuration
// registers are written through the config port, always ready, and must
// only change while idle.
module two_link_leg_forward_kinematics #(
    parameter int ANGLE_BITS  = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [ANGLE_BITS-1:0]                 i_hip_angle,
    input  logic [ANGLE_BITS-1:0]                 i_knee_angle,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [tlfk_pkg::OUT_W-1:0]     o_tip_x,
    output logic signed [tlfk_pkg::OUT_W-1:0]     o_tip_y,
    output logic signed [tlfk_pkg::OUT_W-1:0]     o_tip_z,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tlfk_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tlfk_pkg::ROW_W-1:0]            i_cfg_data
);

    tlfk_pkg::t_cfg       r_cfg;
    tlfk_pkg::t_entry     w_front_entry;
    tlfk_pkg::t_entry     w_queue_entry;
    tlfk_pkg::t_fifo_stat w_fifo_stat;
    logic                 w_push;
    logic                 w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_x     <= tlfk_pkg::ROW_X_RESET;
            r_cfg.row_y     <= tlfk_pkg::ROW_Y_RESET;
            r_cfg.row_z     <= tlfk_pkg::ROW_Z_RESET;
            r_cfg.len_upper <= tlfk_pkg::LEN_RESET;
            r_cfg.len_lower <= tlfk_pkg::LEN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tlfk_pkg::CFG_ROW_X:     r_cfg.row_x     <= i_cfg_data;
                tlfk_pkg::CFG_ROW_Y:     r_cfg.row_y     <= i_cfg_data;
                tlfk_pkg::CFG_ROW_Z:     r_cfg.row_z     <= i_cfg_data;
                tlfk_pkg::CFG_LEN_UPPER: r_cfg.len_upper <= i_cfg_data[tlfk_pkg::LEN_W-1:0];
                tlfk_pkg::CFG_LEN_LOWER: r_cfg.len_lower <= i_cfg_data[tlfk_pkg::LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tlfk_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_hip_angle  (i_hip_angle),
        .i_knee_angle (i_knee_angle),
        .i_fifo_stat  (w_fifo_stat),
        .o_push       (w_push),
        .o_entry      (w_front_entry)
    );

    tlfk_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_front_entry),
        .i_pop   (w_pop),
        .o_entry (w_queue_entry),
        .o_stat  (w_fifo_stat)
    );

    tlfk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_entry     (w_queue_entry),
        .i_fifo_stat (w_fifo_stat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_tip_x     (o_tip_x),
        .o_tip_y     (o_tip_y),
        .o_tip_z     (o_tip_z)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_fifo_stat.full)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_fifo_stat.empty)
        else $error("queue read while empty");

    a_stall_holds_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !w_pop)
        else $error("queue read while output stalled");

    a_backpressure_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> w_fifo_stat.full)
        else $error("input stalled with room in the queue");

endmodule
